// File: rtl/epve_pkg.sv
package epve_pkg;

   // Field widths of the channels and registers.
   localparam int ENC_W      = 14;
   localparam int POS_W      = 48;
   localparam int VEL_OUT_W  = 32;
   localparam int SP_W       = 32;
   localparam int KP_W       = 16;
   localparam int FRAC_W     = 16;

   // Default encoder resolution; must be a power of two from 256 to 65536.
   localparam int COUNTS_PER_REV_DEF = 16384;

   // Register port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_GAIN_KP  = 1'b1;
   localparam logic [SP_W-1:0] SP_RESET = 32'd214748;
   localparam logic [KP_W-1:0] KP_RESET = 16'd100;

   // Shared multiplier: a 48-bit operand is taken in 16-bit chunks against 32 bits.
   localparam int MUL_A_W     = 48;
   localparam int MUL_B_W     = 32;
   localparam int MUL_CHUNK_W = 16;
   localparam int MUL_CHUNKS  = MUL_A_W / MUL_CHUNK_W;
   localparam int MUL_IDX_W   = $clog2(MUL_CHUNKS);
   localparam int MUL_PP_W    = MUL_CHUNK_W + MUL_B_W;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

   // Binary-point shifts of the three products with the sample period.
   localparam int T1_SHIFT = 32;
   localparam int DP_SHIFT = 16;
   localparam int DV_SHIFT = 18;

   typedef enum logic [2:0] {
      OP_VEL,
      OP_EKP,
      OP_EKP2,
      OP_DV,
      OP_DP
   } op_type;

   typedef struct packed {
      logic   load;
      logic   mul_start;
      op_type op;
      logic   capture;
      logic   err_calc;
      logic   update;
      logic   publish;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_done;
   } dp_status_type;

endpackage

// File: rtl/epve_req_if.sv
interface epve_req_if;
   import epve_pkg::*;

   logic             valid;
   logic             ready;
   logic [ENC_W-1:0] encoder_count;

   modport source (output valid, output encoder_count, input ready);
   modport sink (input valid, input encoder_count, output ready);
endinterface

// File: rtl/epve_rsp_if.sv
interface epve_rsp_if;
   import epve_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [POS_W-1:0]     position_turns;
   logic signed [VEL_OUT_W-1:0] velocity_turns;

   modport source (output valid, output position_turns, output velocity_turns, input ready);
   modport sink (input valid, input position_turns, input velocity_turns, output ready);
endinterface

// File: rtl/encoder_pll_velocity_estimator.sv
// Encoder phase-locked-loop velocity estimator. Each request transfer carries one
// absolute encoder count within a revolution; the block tracks it with a
// second-order loop (proportional gain kp, integral gain kp*kp/4, both scaled by
// the sample period) and returns one response transfer holding the multi-turn
// position in turns (signed Q31.16, saturating) and the velocity in turns per
// second (signed Q15.16, saturating). Each sample accepts the count, forms the
// velocity product and the error, runs four error products, updates the loop
// state and loads the output register once it is free. The five products go
// one after another through a single 16x32 multiplier, each in three partial
// products with an issue and a capture step. The next count is accepted as soon as
// the previous response is loaded, even while that response still waits to be taken.
// The sample period and kp are set through the register port at byte addresses 0
// and 4 and should only be changed between samples. COUNTS_PER_REV must be a
// power of two from 256 to 65536; a count at or above it acts as its residue.
module encoder_pll_velocity_estimator #(
   parameter int COUNTS_PER_REV = epve_pkg::COUNTS_PER_REV_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   epve_req_if.sink                        req_if,
   epve_rsp_if.source                      rsp_if,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [epve_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [epve_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [epve_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import epve_pkg::*;

   logic [SP_W-1:0] sample_period;
   logic [KP_W-1:0] loop_gain_kp;
   dp_cmd_type      cmd;
   dp_status_type   status;

   // Configuration registers.
   epve_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (csr_psel),
      .penable       (csr_penable),
      .pwrite        (csr_pwrite),
      .paddr         (csr_paddr),
      .pwdata        (csr_pwdata),
      .prdata        (csr_prdata),
      .pready        (csr_pready),
      .sample_period (sample_period),
      .loop_gain_kp  (loop_gain_kp)
   );

   // Sequencer: walks one sample through the multiplier and owns both handshakes.
   epve_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Loop state, shared multiplier and the response payload registers.
   epve_dp #(
      .COUNTS_PER_REV (COUNTS_PER_REV)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_count      (req_if.encoder_count),
      .sample_period  (sample_period),
      .loop_gain_kp   (loop_gain_kp),
      .cmd            (cmd),
      .status         (status),
      .position_turns (rsp_if.position_turns),
      .velocity_turns (rsp_if.velocity_turns)
   );

   // A new response is loaded only when the output register is free or being emptied.
   a_publish_free : assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_if.valid || rsp_if.ready))
      else $error("response loaded over one not yet transferred");

   // The multiplier signals completion for exactly one cycle.
   a_done_pulse : assert property (@(posedge clock) disable iff (reset)
      status.mul_done |=> !status.mul_done)
      else $error("multiplier done held longer than one cycle");

   // A request is only taken while no sample is in flight.
   a_accept_quiet : assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |-> !(cmd.capture || cmd.update || cmd.publish))
      else $error("request taken while a sample is in progress");

   // A multiplication never reports completion in the cycle after it was started.
   a_mul_latency : assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |=> !status.mul_done)
      else $error("multiplier finished too early");
endmodule

// File: rtl/epve_csr.sv
module epve_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [epve_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [epve_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [epve_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output logic [epve_pkg::SP_W-1:0]         sample_period,
   output logic [epve_pkg::KP_W-1:0]         loop_gain_kp
);
   import epve_pkg::*;

   logic [SP_W-1:0]      sp_ff, sp_in;
   logic [KP_W-1:0]      kp_ff, kp_in;
   logic [CSR_IDX_W-1:0] idx;
   logic                 wr;

   assign idx    = paddr[CSR_ADDR_W-1:2];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      sp_in = sp_ff;
      kp_in = kp_ff;
      if (wr) begin
         unique case (idx)
            CSR_SAMPLE_PERIOD: sp_in = pwdata[SP_W-1:0];
            CSR_LOOP_GAIN_KP:  kp_in = pwdata[KP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         CSR_SAMPLE_PERIOD: prdata = CSR_DATA_W'(sp_ff);
         CSR_LOOP_GAIN_KP:  prdata = CSR_DATA_W'(kp_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= SP_RESET;
         kp_ff <= KP_RESET;
      end else begin
         sp_ff <= sp_in;
         kp_ff <= kp_in;
      end
   end

   assign sample_period = sp_ff;
   assign loop_gain_kp  = kp_ff;
endmodule

// File: rtl/epve_mul.sv
module epve_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [epve_pkg::MUL_A_W-1:0]   a,
   input  logic [epve_pkg::MUL_B_W-1:0]   b,
   output logic                           done,
   output logic [epve_pkg::MUL_P_W-1:0]   product
);
   import epve_pkg::*;

   localparam logic [MUL_IDX_W-1:0] LAST = MUL_IDX_W'(MUL_CHUNKS - 1);

   logic                 run_ff, run_in;
   logic                 ppv_ff, ppv_in;
   logic                 done_ff, done_in;
   logic [MUL_IDX_W-1:0] issue_ff, issue_in;
   logic [MUL_IDX_W-1:0] pp_idx_ff, pp_idx_in;
   logic [MUL_A_W-1:0]   a_sh_ff, a_sh_in;
   logic [MUL_B_W-1:0]   b_ff, b_in;
   logic [MUL_PP_W-1:0]  pp_ff, pp_in;
   logic [MUL_P_W-1:0]   acc_ff, acc_in;

   always_comb begin
      run_in    = run_ff;
      issue_in  = issue_ff;
      pp_idx_in = pp_idx_ff;
      a_sh_in   = a_sh_ff;
      b_in      = b_ff;
      pp_in     = pp_ff;
      acc_in    = acc_ff;
      ppv_in    = run_ff && !start;
      done_in   = ppv_ff && (pp_idx_ff == LAST);

      // Partial products are registered, then shifted into place in the cycle after.
      if (ppv_ff) begin
         acc_in = acc_ff + (MUL_P_W'(pp_ff) << (MUL_CHUNK_W * pp_idx_ff));
      end

      if (start) begin
         a_sh_in  = a;
         b_in     = b;
         issue_in = '0;
         run_in   = 1'b1;
         acc_in   = '0;
      end else if (run_ff) begin
         pp_in     = MUL_PP_W'(a_sh_ff[MUL_CHUNK_W-1:0]) * MUL_PP_W'(b_ff);
         pp_idx_in = issue_ff;
         a_sh_in   = a_sh_ff >> MUL_CHUNK_W;
         issue_in  = MUL_IDX_W'(issue_ff + 1'b1);
         if (issue_ff == LAST) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         ppv_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         ppv_ff  <= ppv_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff  <= issue_in;
      pp_idx_ff <= pp_idx_in;
      a_sh_ff   <= a_sh_in;
      b_ff      <= b_in;
      pp_ff     <= pp_in;
      acc_ff    <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

// File: rtl/epve_dp.sv
module epve_dp #(
   parameter int COUNTS_PER_REV = epve_pkg::COUNTS_PER_REV_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [epve_pkg::ENC_W-1:0]            req_count,
   input  logic [epve_pkg::SP_W-1:0]             sample_period,
   input  logic [epve_pkg::KP_W-1:0]             loop_gain_kp,
   input  epve_pkg::dp_cmd_type                  cmd,
   output epve_pkg::dp_status_type               status,
   output logic signed [epve_pkg::POS_W-1:0]     position_turns,
   output logic signed [epve_pkg::VEL_OUT_W-1:0] velocity_turns
);
   import epve_pkg::*;

   localparam int CB      = $clog2(COUNTS_PER_REV);
   localparam int PHW     = CB + FRAC_W;
   localparam int EKP_W   = CB + 15;
   localparam int EKP2_W  = CB + 31;
   localparam int DVM_W   = CB + 45;
   localparam int VSUM_W  = DVM_W + 2;
   localparam int DQ_W    = PHW - CB;
   localparam int TSUM_W  = POS_W + 1;

   logic [ENC_W-1:0]            count_ff, count_in;
   logic [PHW-1:0]              p1_ff, p1_in;
   logic signed [CB-1:0]        err_ff, err_in;
   logic [EKP_W-1:0]            ekp_ff, ekp_in;
   logic [EKP2_W-1:0]           ekp2_ff, ekp2_in;
   logic [DVM_W-1:0]            dvm_ff, dvm_in;
   logic [PHW-1:0]              dpl_ff, dpl_in;
   logic [PHW-1:0]              phase_ff, phase_in;
   logic [PHW-1:0]              last_ff, last_in;
   logic signed [POS_W-1:0]     vel_ff, vel_in;
   logic signed [POS_W-1:0]     total_ff, total_in;
   logic signed [VEL_OUT_W-1:0] vout_ff, vout_in;

   logic [MUL_A_W-1:0]          mul_a;
   logic [MUL_B_W-1:0]          mul_b;
   logic [MUL_P_W-1:0]          prod;
   logic                        mul_done;

   logic                        vel_neg, err_neg;
   logic [MUL_A_W-1:0]          vel_mag;
   logic [CB-1:0]               err_mag;
   logic [PHW-1:0]              t1, t1_s, dp_mag;
   logic [VSUM_W-1:0]           dvu;
   logic signed [VSUM_W-1:0]    dvs, vsum;
   logic [VSUM_W-POS_W:0]       vsum_hi;
   logic signed [POS_W-1:0]     vsat;
   logic [PHW-1:0]              dph;
   logic signed [DQ_W-1:0]      dq;
   logic signed [TSUM_W-1:0]    tsum;
   logic signed [POS_W-1:0]     tsat;
   logic signed [POS_W-1:0]     vsh;
   logic [POS_W-VEL_OUT_W:0]    vsh_hi;
   logic signed [VEL_OUT_W-1:0] voutsat;

   epve_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (prod)
   );

   assign status.mul_done = mul_done;

   // Products are formed on magnitudes and the sign is put back afterward,
   // which truncates each scaled product toward zero.
   assign vel_neg = vel_ff[POS_W-1];
   assign err_neg = err_ff[CB-1];
   assign vel_mag = vel_neg ? -$unsigned(vel_ff) : $unsigned(vel_ff);
   assign err_mag = err_neg ? -$unsigned(err_ff) : $unsigned(err_ff);

   always_comb begin
      unique case (cmd.op)
         OP_VEL: begin
            mul_a = vel_mag;
            mul_b = sample_period;
         end
         OP_EKP: begin
            mul_a = MUL_A_W'(err_mag);
            mul_b = MUL_B_W'(loop_gain_kp);
         end
         OP_EKP2: begin
            mul_a = MUL_A_W'(ekp_ff);
            mul_b = MUL_B_W'(loop_gain_kp);
         end
         OP_DV: begin
            mul_a = MUL_A_W'(ekp2_ff);
            mul_b = sample_period;
         end
         OP_DP: begin
            mul_a = MUL_A_W'(ekp_ff);
            mul_b = sample_period;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // The phase lives modulo one revolution, so only its low bits are ever needed.
   assign t1     = prod[T1_SHIFT +: PHW];
   assign t1_s   = vel_neg ? -t1 : t1;
   assign dp_mag = prod[DP_SHIFT +: PHW];

   // Velocity correction and 48-bit saturation.
   assign dvu     = VSUM_W'(dvm_ff);
   assign dvs     = err_neg ? $signed(-dvu) : $signed(dvu);
   assign vsum    = VSUM_W'(vel_ff) + dvs;
   assign vsum_hi = vsum[VSUM_W-1:POS_W-1];
   assign vsat    = ((&vsum_hi) || !(|vsum_hi)) ? vsum[POS_W-1:0]
                  : {vsum[VSUM_W-1], {(POS_W-1){~vsum[VSUM_W-1]}}};

   // Wrapped phase change in whole fractional turns, floored.
   assign dph  = phase_ff - last_ff;
   assign dq   = $signed(dph[PHW-1:CB]);
   assign tsum = TSUM_W'(total_ff) + TSUM_W'(dq);
   assign tsat = (tsum[TSUM_W-1] == tsum[TSUM_W-2]) ? tsum[POS_W-1:0]
               : {tsum[TSUM_W-1], {(POS_W-1){~tsum[TSUM_W-1]}}};

   // Velocity in turns per second, floored and saturated to the output width.
   assign vsh     = vel_ff >>> CB;
   assign vsh_hi  = vsh[POS_W-1:VEL_OUT_W-1];
   assign voutsat = ((&vsh_hi) || !(|vsh_hi)) ? vsh[VEL_OUT_W-1:0]
                  : {vsh[POS_W-1], {(VEL_OUT_W-1){~vsh[POS_W-1]}}};

   always_comb begin
      count_in = count_ff;
      p1_in    = p1_ff;
      err_in   = err_ff;
      ekp_in   = ekp_ff;
      ekp2_in  = ekp2_ff;
      dvm_in   = dvm_ff;
      dpl_in   = dpl_ff;
      phase_in = phase_ff;
      last_in  = last_ff;
      vel_in   = vel_ff;
      total_in = total_ff;
      vout_in  = vout_ff;

      if (cmd.load) begin
         count_in = req_count;
      end

      if (cmd.capture) begin
         unique case (cmd.op)
            OP_VEL:  p1_in   = phase_ff + t1_s;
            OP_EKP:  ekp_in  = prod[EKP_W-1:0];
            OP_EKP2: ekp2_in = prod[EKP2_W-1:0];
            OP_DV:   dvm_in  = prod[DV_SHIFT +: DVM_W];
            OP_DP:   dpl_in  = err_neg ? -dp_mag : dp_mag;
            default: ;
         endcase
      end

      // The count residue minus the floored phase, read as a signed half-turn window.
      if (cmd.err_calc) begin
         err_in = $signed(CB'(count_ff) - p1_ff[FRAC_W +: CB]);
      end

      if (cmd.update) begin
         vel_in   = vsat;
         phase_in = p1_ff + dpl_ff;
         last_in  = phase_ff;
      end

      if (cmd.publish) begin
         total_in = tsat;
         vout_in  = voutsat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         vel_ff   <= '0;
         total_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         vel_ff   <= vel_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      p1_ff    <= p1_in;
      err_ff   <= err_in;
      ekp_ff   <= ekp_in;
      ekp2_ff  <= ekp2_in;
      dvm_ff   <= dvm_in;
      dpl_ff   <= dpl_in;
      last_ff  <= last_in;
      vout_ff  <= vout_in;
   end

   assign position_turns = total_ff;
   assign velocity_turns = vout_ff;
endmodule

// File: rtl/epve_ctrl.sv
module epve_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output epve_pkg::dp_cmd_type     cmd,
   input  epve_pkg::dp_status_type  status
);
   import epve_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ISSUE = 6'b000010,
      ST_WAIT  = 6'b000100,
      ST_ERR   = 6'b001000,
      ST_UPD   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      cmd       = '0;
      cmd.op    = op_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in    = OP_VEL;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.mul_done) begin
               cmd.capture = 1'b1;
               unique case (op_ff)
                  OP_VEL:  state_in = ST_ERR;
                  OP_EKP: begin
                     op_in    = OP_EKP2;
                     state_in = ST_ISSUE;
                  end
                  OP_EKP2: begin
                     op_in    = OP_DV;
                     state_in = ST_ISSUE;
                  end
                  OP_DV: begin
                     op_in    = OP_DP;
                     state_in = ST_ISSUE;
                  end
                  OP_DP:   state_in = ST_UPD;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ERR: begin
            cmd.err_calc = 1'b1;
            op_in        = OP_EKP;
            state_in     = ST_ISSUE;
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_VEL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
